@@ rtl/nfe_pkg.sv @@
// shared types, character codes and helper functions for the nmea field extractor
`default_nettype none
package nfe_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [2:0] SEL_SATS     = 3'd0;
  localparam logic [2:0] SEL_SPEED    = 3'd1;
  localparam logic [2:0] SEL_DATE     = 3'd2;
  localparam logic [2:0] SEL_TIME     = 3'd3;
  localparam logic [2:0] SEL_POSITION = 3'd4;
  localparam logic [2:0] SEL_HEIGHT   = 3'd5;
  localparam logic [2:0] SEL_HEADING  = 3'd6;

  localparam logic CFG_FIELD_SELECT = 1'b0;
  localparam logic CFG_HOUR_OFFSET  = 1'b1;

  localparam logic [4:0] HOUR_OFFSET_RESET = 5'd8;
  localparam logic [7:0] HOURS_PER_DAY     = 8'd24;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // one queue entry: the one or two characters one byte produces
  typedef struct packed {
    logic [7:0] c0;
    logic       l0;
    logic       two;
    logic [7:0] c1;
    logic       l1;
  } nfe_entry_t;

  typedef struct packed {
    logic       push;
    nfe_entry_t entry;
  } nfe_push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // two hour digit characters plus offset, mod 24, back to two characters
  function automatic logic [15:0] hour_adjust(input logic [7:0] tens_c,
                                              input logic [7:0] ones_c,
                                              input logic [4:0] ofs);
    logic [7:0] h;
    logic [7:0] t;
    logic [7:0] o;
    h = {1'b0, tens_c[3:0], 3'b000} + {3'b000, tens_c[3:0], 1'b0}
        + {4'h0, ones_c[3:0]} + {3'b000, ofs};
    // for digit characters the sum is at most 130, so one subtraction of a multiple of 24 suffices
    if (h >= 8'd120) begin
      h = h - 8'd120;
    end else if (h >= 8'd96) begin
      h = h - 8'd96;
    end else if (h >= 8'd72) begin
      h = h - 8'd72;
    end else if (h >= 8'd48) begin
      h = h - 8'd48;
    end else if (h >= HOURS_PER_DAY) begin
      h = h - HOURS_PER_DAY;
    end
    if (h >= 8'd20) begin
      t = 8'd2;
      o = h - 8'd20;
    end else if (h >= 8'd10) begin
      t = 8'd1;
      o = h - 8'd10;
    end else begin
      t = 8'd0;
      o = h;
    end
    return {CH_ZERO + t, CH_ZERO + o};
  endfunction

endpackage
`default_nettype wire

@@ rtl/nfe_front.sv @@
// front end: configuration, sentence tracking and per-byte character generation
`default_nettype none
module nfe_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [4:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_rx_byte,
  input  wire logic               q_full,
  output nfe_pkg::nfe_push_t      q_push
);
  import nfe_pkg::*;

  logic [2:0] sel_r;
  logic [4:0] ofs_r;
  logic       in_sent_r, in_sent_nxt;
  logic [2:0] hpos_r, hpos_nxt;
  logic [7:0] type_r [3];
  logic [7:0] type_nxt [3];
  logic [3:0] ccnt_r, ccnt_nxt;
  logic       sv_r, sv_nxt;
  logic [3:0] fci_r, fci_nxt;
  logic [7:0] held_r, held_nxt;
  logic       done_r, done_nxt;
  logic       open_r, open_nxt;

  logic       accept;
  logic       comma;
  logic       gga, rmc;
  logic [1:0] n;
  logic [7:0] c0, c1;
  logic       l0, l1;
  logic [3:0] k;
  logic [15:0] hr;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign comma    = (in_rx_byte == CH_COMMA);
  assign hr       = hour_adjust(held_r, in_rx_byte, ofs_r);

  always_comb begin
    in_sent_nxt = in_sent_r;
    hpos_nxt    = hpos_r;
    for (int i = 0; i < 3; i++) begin
      type_nxt[i] = type_r[i];
    end
    ccnt_nxt = ccnt_r;
    sv_nxt   = sv_r;
    fci_nxt  = fci_r;
    held_nxt = held_r;
    done_nxt = done_r;
    open_nxt = open_r;
    n  = 2'd0;
    c0 = CH_NUL;
    l0 = 1'b0;
    c1 = CH_NUL;
    l1 = 1'b0;
    k  = 4'd2;
    gga = 1'b0;
    rmc = 1'b0;

    if (in_rx_byte == CH_DOLLAR) begin
      if (open_r && !done_r) begin
        n  = 2'd1;
        c0 = CH_NUL;
        l0 = 1'b1;
      end
      in_sent_nxt = 1'b1;
      hpos_nxt    = 3'd1;
      for (int i = 0; i < 3; i++) begin
        type_nxt[i] = 8'h00;
      end
      ccnt_nxt = 4'd0;
      sv_nxt   = 1'b0;
      fci_nxt  = 4'd0;
      held_nxt = 8'h00;
      done_nxt = 1'b0;
      open_nxt = 1'b0;
    end else if (in_sent_r) begin
      // header letters
      if (hpos_r == 3'd3) type_nxt[0] = in_rx_byte;
      if (hpos_r == 3'd4) type_nxt[1] = in_rx_byte;
      if (hpos_r == 3'd5) type_nxt[2] = in_rx_byte;
      if (hpos_r < 3'd7) hpos_nxt = hpos_r + 3'd1;

      gga = (type_nxt[0] == CH_G) && (type_nxt[1] == CH_G) && (type_nxt[2] == CH_A);
      rmc = (type_nxt[0] == CH_R) && (type_nxt[1] == CH_M) && (type_nxt[2] == CH_C);

      // status check on the first byte of a field
      if (fci_r == 4'd0) begin
        if ((sel_r == SEL_SPEED || sel_r == SEL_DATE || sel_r == SEL_HEADING)
            && ccnt_r == 4'd2) begin
          sv_nxt = rmc && (in_rx_byte == CH_A);
        end else if ((sel_r == SEL_SATS || sel_r == SEL_POSITION || sel_r == SEL_HEIGHT)
                     && ccnt_r == 4'd1) begin
          sv_nxt = gga && !comma;
        end else if (sel_r == SEL_TIME && ccnt_r == 4'd1) begin
          sv_nxt = (gga || rmc) && !comma;
        end
      end

      if (sv_nxt && !done_r) begin
        unique case (sel_r)
          SEL_SATS, SEL_SPEED, SEL_DATE, SEL_HEADING: begin
            if ((ccnt_r == 4'd7 && (sel_r == SEL_SATS || sel_r == SEL_SPEED))
                || (ccnt_r == 4'd9 && sel_r == SEL_DATE)
                || (ccnt_r == 4'd8 && sel_r == SEL_HEADING)) begin
              n  = 2'd1;
              c0 = comma ? CH_NUL : in_rx_byte;
              l0 = comma;
            end
          end
          SEL_TIME: begin
            if (ccnt_r == 4'd1) begin
              if (comma) begin
                if (fci_r == 4'd1) begin
                  n  = 2'd2;
                  c0 = held_r;
                  l0 = 1'b0;
                  c1 = CH_NUL;
                  l1 = 1'b1;
                end else begin
                  n  = 2'd1;
                  c0 = CH_NUL;
                  l0 = 1'b1;
                end
              end else if (fci_r == 4'd0) begin
                held_nxt = in_rx_byte;
              end else if (fci_r == 4'd1) begin
                n = 2'd2;
                if (is_digit(held_r) && is_digit(in_rx_byte)) begin
                  c0 = hr[15:8];
                  c1 = hr[7:0];
                end else begin
                  c0 = held_r;
                  c1 = in_rx_byte;
                end
              end else begin
                n  = 2'd1;
                c0 = in_rx_byte;
              end
            end
          end
          SEL_POSITION: begin
            if ((ccnt_r == 4'd2 || ccnt_r == 4'd4) && !comma) begin
              k = (ccnt_r == 4'd2) ? 4'd2 : 4'd3;
              n = 2'd1;
              if (fci_r < k) begin
                c0 = in_rx_byte;
              end else if (fci_r == k) begin
                c0       = CH_DOT;
                held_nxt = in_rx_byte;
              end else if (fci_r == k + 4'd1) begin
                c0       = held_r;
                held_nxt = in_rx_byte;
              end else if (fci_r == k + 4'd2) begin
                c0 = held_r;
              end else begin
                c0 = in_rx_byte;
              end
            end else if (ccnt_r == 4'd3 && fci_r == 4'd0) begin
              n  = 2'd1;
              c0 = in_rx_byte;
            end else if (ccnt_r == 4'd5 && fci_r == 4'd0) begin
              n  = 2'd2;
              c0 = in_rx_byte;
              c1 = CH_NUL;
              l1 = 1'b1;
            end
          end
          SEL_HEIGHT: begin
            if (ccnt_r == 4'd9 && !comma) begin
              n  = 2'd1;
              c0 = in_rx_byte;
            end else if (ccnt_r == 4'd10 && fci_r == 4'd0) begin
              n  = 2'd2;
              c0 = in_rx_byte;
              c1 = CH_NUL;
              l1 = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      // record tracking follows the last character produced
      if (n == 2'd1) begin
        done_nxt = l0 ? 1'b1 : done_r;
        open_nxt = !l0;
      end else if (n == 2'd2) begin
        done_nxt = l1 ? 1'b1 : done_r;
        open_nxt = !l1;
      end

      if (comma) begin
        if (ccnt_r != 4'd15) ccnt_nxt = ccnt_r + 4'd1;
        fci_nxt = 4'd0;
      end else if (fci_r != 4'd15) begin
        fci_nxt = fci_r + 4'd1;
      end
    end
  end

  assign q_push.push     = accept && (n != 2'd0);
  assign q_push.entry.c0 = c0;
  assign q_push.entry.l0 = l0;
  assign q_push.entry.two = (n == 2'd2);
  assign q_push.entry.c1 = c1;
  assign q_push.entry.l1 = l1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r     <= SEL_SATS;
      ofs_r     <= HOUR_OFFSET_RESET;
      in_sent_r <= 1'b0;
      hpos_r    <= 3'd0;
      for (int i = 0; i < 3; i++) begin
        type_r[i] <= 8'h00;
      end
      ccnt_r <= 4'd0;
      sv_r   <= 1'b0;
      fci_r  <= 4'd0;
      held_r <= 8'h00;
      done_r <= 1'b0;
      open_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FIELD_SELECT) sel_r <= cfg_data[2:0];
        if (cfg_index == CFG_HOUR_OFFSET) ofs_r <= cfg_data;
      end
      if (accept) begin
        in_sent_r <= in_sent_nxt;
        hpos_r    <= hpos_nxt;
        for (int i = 0; i < 3; i++) begin
          type_r[i] <= type_nxt[i];
        end
        ccnt_r <= ccnt_nxt;
        sv_r   <= sv_nxt;
        fci_r  <= fci_nxt;
        held_r <= held_nxt;
        done_r <= done_nxt;
        open_r <= open_nxt;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/nfe_fifo.sv @@
// short queue of generated character pairs between front and back end
`default_nettype none
module nfe_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  nfe_pkg::nfe_push_t      q_push,
  output logic                    q_full,
  output logic                    q_empty,
  output nfe_pkg::nfe_entry_t     q_head,
  input  wire logic               q_pop
);
  import nfe_pkg::*;

  nfe_entry_t                mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]     wr_r, wr_nxt;
  logic [FIFO_PTR_W-1:0]     rd_r, rd_nxt;
  logic [FIFO_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                      do_push, do_pop;

  assign q_full  = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign q_head  = mem_r[rd_r];
  assign do_push = q_push.push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= q_push.entry;
    end
  end

endmodule
`default_nettype wire

@@ rtl/nfe_back.sv @@
// back end: unpacks queue entries into single characters on the output register
`default_nettype none
module nfe_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  nfe_pkg::nfe_entry_t     q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_char,
  output logic                    out_last
);
  import nfe_pkg::*;

  logic       vld_r, vld_nxt;
  logic [7:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic       sec_vld_r, sec_vld_nxt;
  logic [7:0] sec_char_r, sec_char_nxt;
  logic       sec_last_r, sec_last_nxt;
  logic       slot_free;

  assign slot_free = !vld_r || out_ready;
  assign q_pop     = slot_free && !sec_vld_r && !q_empty;

  always_comb begin
    vld_nxt      = vld_r;
    char_nxt     = char_r;
    last_nxt     = last_r;
    sec_vld_nxt  = sec_vld_r;
    sec_char_nxt = sec_char_r;
    sec_last_nxt = sec_last_r;
    if (slot_free) begin
      if (sec_vld_r) begin
        vld_nxt     = 1'b1;
        char_nxt    = sec_char_r;
        last_nxt    = sec_last_r;
        sec_vld_nxt = 1'b0;
      end else if (!q_empty) begin
        vld_nxt      = 1'b1;
        char_nxt     = q_head.c0;
        last_nxt     = q_head.l0;
        sec_vld_nxt  = q_head.two;
        sec_char_nxt = q_head.c1;
        sec_last_nxt = q_head.l1;
      end else begin
        vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      sec_vld_r <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      sec_vld_r <= sec_vld_nxt;
    end
    char_r     <= char_nxt;
    last_r     <= last_nxt;
    sec_char_r <= sec_char_nxt;
    sec_last_r <= sec_last_nxt;
  end

  assign out_valid = vld_r;
  assign out_char  = char_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

@@ rtl/nmea_field_extractor.sv @@
// top level of the nmea field extractor: front end, queue and back end
// Usage:
//   in_valid/in_ready/in_rx_byte carry the received character stream, one
//   character per request. out_valid/out_ready/out_char/out_last deliver the
//   extracted record characters; the zero byte that ends a record has
//   out_last high. cfg_we/cfg_index/cfg_data write field_select (index 0)
//   and hour_offset (index 1) while the block is idle.
//   Throughput: one input character per cycle while the queue is not full.
//   A character that yields two output characters holds the single output
//   register for both in turn, so sustained input rate follows output
//   bandwidth when records run dense. An accepted character goes to the
//   queue, then to the output register, its second after the first is taken.
//   A two-entry queue between the parser and the output stage absorbs
//   receiver stalls; in_ready drops only when the queue is full.
//   Reset: synchronous, active low; clears the parser state, empties the
//   queue and output register, and sets field_select 0 and hour_offset 8.
`default_nettype none
module nmea_field_extractor (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [4:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            out_last
);
  import nfe_pkg::*;

  nfe_push_t  q_push;
  nfe_entry_t q_head;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;

  nfe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push)
  );

  nfe_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  nfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule
`default_nettype wire
